/* hw/rtl/tkpd_pkg.sv */
// two-key priority dispatcher: shared codes, widths and the
// controller to datapath command and status structs
// no dependencies
package tkpd_pkg;

  // operation codes of a request
  localparam logic [1:0] FUNC_APPEND  = 2'd0;
  localparam logic [1:0] FUNC_PROCESS = 2'd1;
  localparam logic [1:0] FUNC_SETTLE  = 2'd2;
  localparam logic [1:0] FUNC_CLEAR   = 2'd3;

  // result status codes
  localparam logic [2:0] ST_DISPATCHED = 3'd0;
  localparam logic [2:0] ST_NONE       = 3'd1;
  localparam logic [2:0] ST_APPENDED   = 3'd2;
  localparam logic [2:0] ST_FULL       = 3'd3;
  localparam logic [2:0] ST_SETTLED    = 3'd4;
  localparam logic [2:0] ST_NOT_ACTIVE = 3'd5;
  localparam logic [2:0] ST_CLEARED    = 3'd6;

  // field widths
  localparam int unsigned FUNC_W  = 2;
  localparam int unsigned ID_W    = 8;
  localparam int unsigned PRIO_W  = 16;
  localparam int unsigned EXT_W   = 8;
  localparam int unsigned STAT_W  = 3;
  localparam int unsigned CNT_W   = 7;
  localparam int unsigned SEQ_W   = 16;
  localparam int unsigned KEY_W   = 2 * PRIO_W + SEQ_W;
  localparam int unsigned ENTRY_W = ID_W + 2 * PRIO_W + SEQ_W;

  // most dispatches caused by one process request
  localparam logic [6:0] MAX_RESULTS = 7'd64;

  // commit operations issued by the controller
  typedef enum logic [2:0] {
    OP_NONE,
    OP_APPEND,
    OP_NO_DISPATCH,
    OP_DISPATCH,
    OP_SETTLE,
    OP_CLEAR
  } commit_e;

  typedef struct packed {
    logic    load;        // latch the request payload
    logic    scan_start;  // restart the store scan
    logic    scan_run;    // step the store scan
    commit_e op;          // state update plus one result
  } cmd_t;

  typedef struct packed {
    logic scan_done;  // every entry has been looked at
    logic stop;       // process may not dispatch again
    logic last_next;  // a dispatch now would be the final one
    logic out_free;   // output register can take a result
  } sts_t;

endpackage

/* hw/rtl/tkpd_req_if.sv */
// request channel of the dispatcher: valid/ready plus payload
// depends on tkpd_pkg
interface tkpd_req_if;
  logic                             valid;
  logic                             ready;
  logic [tkpd_pkg::FUNC_W-1:0]      func;
  logic [tkpd_pkg::ID_W-1:0]        request_id;
  logic [tkpd_pkg::PRIO_W-1:0]      tree_priority;
  logic [tkpd_pkg::PRIO_W-1:0]      request_priority;
  logic [tkpd_pkg::EXT_W-1:0]       external_in_flight;

  modport source (
    output valid, func, request_id, tree_priority, request_priority, external_in_flight,
    input  ready
  );
  modport sink (
    input  valid, func, request_id, tree_priority, request_priority, external_in_flight,
    output ready
  );
endinterface

/* hw/rtl/tkpd_rsp_if.sv */
// result channel of the dispatcher: valid/ready plus payload
// depends on tkpd_pkg
interface tkpd_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [tkpd_pkg::STAT_W-1:0]   status;
  logic [tkpd_pkg::ID_W-1:0]     dispatched_id;
  logic                          last;
  logic [tkpd_pkg::CNT_W-1:0]    active_count;
  logic [tkpd_pkg::CNT_W-1:0]    pending_count;

  modport source (
    output valid, status, dispatched_id, last, active_count, pending_count,
    input  ready
  );
  modport sink (
    input  valid, status, dispatched_id, last, active_count, pending_count,
    output ready
  );
endinterface

/* hw/rtl/tkpd_ram.sv */
// generic single write port ram with registered read
// no dependencies
module tkpd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                           wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                           rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/tkpd_ctrl.sv */
// controller state machine of the dispatcher
// depends on tkpd_pkg; drives tkpd_dpath through cmd_t / sts_t
module tkpd_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        req_valid_i,
  input  logic [tkpd_pkg::FUNC_W-1:0] req_func_i,
  output logic                        req_ready_o,
  input  tkpd_pkg::sts_t              sts_i,
  output tkpd_pkg::cmd_t              cmd_o
);

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_APP_SCAN  = 4'd1;
  localparam logic [3:0] S_APP_DONE  = 4'd2;
  localparam logic [3:0] S_PROC_CHK  = 4'd3;
  localparam logic [3:0] S_PROC_SCAN = 4'd4;
  localparam logic [3:0] S_PROC_DONE = 4'd5;
  localparam logic [3:0] S_SET_SCAN  = 4'd6;
  localparam logic [3:0] S_SET_DONE  = 4'd7;
  localparam logic [3:0] S_CLR       = 4'd8;

  logic [3:0] state_q, state_d;

  assign req_ready_o = (state_q == S_IDLE);

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '{load: 1'b0, scan_start: 1'b0, scan_run: 1'b0, op: tkpd_pkg::OP_NONE};
    case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          cmd_o.load       = 1'b1;
          cmd_o.scan_start = 1'b1;
          case (req_func_i)
            tkpd_pkg::FUNC_APPEND:  state_d = S_APP_SCAN;
            tkpd_pkg::FUNC_PROCESS: state_d = S_PROC_CHK;
            tkpd_pkg::FUNC_SETTLE:  state_d = S_SET_SCAN;
            default:                state_d = S_CLR;
          endcase
        end
      end
      S_APP_SCAN: begin
        if (sts_i.scan_done) state_d = S_APP_DONE;
        else cmd_o.scan_run = 1'b1;
      end
      S_APP_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.op = tkpd_pkg::OP_APPEND;
          state_d  = S_IDLE;
        end
      end
      S_PROC_CHK: begin
        if (sts_i.stop) begin
          if (sts_i.out_free) begin
            cmd_o.op = tkpd_pkg::OP_NO_DISPATCH;
            state_d  = S_IDLE;
          end
        end else begin
          cmd_o.scan_start = 1'b1;
          state_d          = S_PROC_SCAN;
        end
      end
      S_PROC_SCAN: begin
        if (sts_i.scan_done) state_d = S_PROC_DONE;
        else cmd_o.scan_run = 1'b1;
      end
      S_PROC_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.op = tkpd_pkg::OP_DISPATCH;
          if (sts_i.last_next) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.scan_start = 1'b1;
            state_d          = S_PROC_SCAN;
          end
        end
      end
      S_SET_SCAN: begin
        if (sts_i.scan_done) state_d = S_SET_DONE;
        else cmd_o.scan_run = 1'b1;
      end
      S_SET_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.op = tkpd_pkg::OP_SETTLE;
          state_d  = S_IDLE;
        end
      end
      S_CLR: begin
        if (sts_i.out_free) begin
          cmd_o.op = tkpd_pkg::OP_CLEAR;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* hw/rtl/tkpd_dpath.sv */
// datapath of the dispatcher: stores, scan engine, counters, result register
// depends on tkpd_pkg and tkpd_ram
module tkpd_dpath #(
  parameter int unsigned PENDING_DEPTH = 64,
  parameter int unsigned ACTIVE_DEPTH  = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [tkpd_pkg::CNT_W-1:0]    cfg_wdata_i,
  input  logic [tkpd_pkg::ID_W-1:0]     req_id_i,
  input  logic [tkpd_pkg::PRIO_W-1:0]   req_tree_i,
  input  logic [tkpd_pkg::PRIO_W-1:0]   req_prio_i,
  input  logic [tkpd_pkg::EXT_W-1:0]    req_ext_i,
  input  tkpd_pkg::cmd_t                cmd_i,
  output tkpd_pkg::sts_t                sts_o,
  output logic                          rsp_valid_o,
  input  logic                          rsp_ready_i,
  output logic [tkpd_pkg::STAT_W-1:0]   rsp_status_o,
  output logic [tkpd_pkg::ID_W-1:0]     rsp_id_o,
  output logic                          rsp_last_o,
  output logic [tkpd_pkg::CNT_W-1:0]    rsp_active_o,
  output logic [tkpd_pkg::CNT_W-1:0]    rsp_pending_o
);

  localparam int unsigned PAW    = $clog2(PENDING_DEPTH);
  localparam int unsigned AAW    = (ACTIVE_DEPTH > 1) ? $clog2(ACTIVE_DEPTH) : 1;
  localparam int unsigned PCW    = $clog2(PENDING_DEPTH + 1);
  localparam int unsigned ACW    = $clog2(ACTIVE_DEPTH + 1);
  localparam int unsigned SCAN_N = (PENDING_DEPTH > ACTIVE_DEPTH) ? PENDING_DEPTH
                                                                  : ACTIVE_DEPTH;
  localparam int unsigned SW     = $clog2(SCAN_N + 1);
  localparam int unsigned SUMW   = ((ACW > tkpd_pkg::EXT_W) ? ACW : tkpd_pkg::EXT_W) + 1;
  localparam int unsigned DCW    = 7;

  // latched request and configuration
  logic [tkpd_pkg::ID_W-1:0]   id_q;
  logic [tkpd_pkg::PRIO_W-1:0] tree_q, prio_q;
  logic [tkpd_pkg::EXT_W-1:0]  ext_q;
  logic [tkpd_pkg::CNT_W-1:0]  max_q;
  logic [tkpd_pkg::SEQ_W-1:0]  seq_q;

  // store state
  logic [PENDING_DEPTH-1:0] pend_vld_q;
  logic [ACTIVE_DEPTH-1:0]  act_vld_q;
  logic [PCW-1:0]           pend_cnt_q, pend_cnt_nx;
  logic [ACW-1:0]           act_cnt_q, act_cnt_nx;
  logic [DCW-1:0]           disp_cnt_q;

  // scan engine
  logic [SW-1:0]  idx_q, rd_idx_q;
  logic           rd_vld_q;
  logic           best_found_q, free_p_found_q, free_a_found_q, hit_found_q;
  logic [PAW-1:0] best_idx_q, free_p_idx_q;
  logic [AAW-1:0] free_a_idx_q, hit_idx_q;
  logic [tkpd_pkg::KEY_W-1:0] best_key_q;
  logic [tkpd_pkg::ID_W-1:0]  best_id_q;

  // result register
  logic                          out_vld_q;
  logic [tkpd_pkg::STAT_W-1:0]   out_stat_q;
  logic [tkpd_pkg::ID_W-1:0]     out_id_q;
  logic                          out_last_q;
  logic [tkpd_pkg::CNT_W-1:0]    out_act_q, out_pend_q;

  // memories
  logic [tkpd_pkg::ENTRY_W-1:0] pend_rdata;
  logic [tkpd_pkg::ID_W-1:0]    act_rdata;
  logic                         pend_we, act_we;

  assign pend_we = (cmd_i.op == tkpd_pkg::OP_APPEND) && free_p_found_q;
  assign act_we  = (cmd_i.op == tkpd_pkg::OP_DISPATCH);

  tkpd_ram #(.WIDTH(tkpd_pkg::ENTRY_W), .DEPTH(PENDING_DEPTH)) u_pend_ram (
    .clk_i   (clk_i),
    .we_i    (pend_we),
    .waddr_i (free_p_idx_q),
    .wdata_i ({id_q, tree_q, prio_q, seq_q}),
    .raddr_i (idx_q[PAW-1:0]),
    .rdata_o (pend_rdata)
  );

  tkpd_ram #(.WIDTH(tkpd_pkg::ID_W), .DEPTH(ACTIVE_DEPTH)) u_act_ram (
    .clk_i   (clk_i),
    .we_i    (act_we),
    .waddr_i (free_a_idx_q),
    .wdata_i (best_id_q),
    .raddr_i (idx_q[AAW-1:0]),
    .rdata_o (act_rdata)
  );

  // candidate evaluation on the data read in the previous cycle
  logic                        rd_p_in, rd_a_in, p_vld, a_vld;
  logic [tkpd_pkg::SEQ_W-1:0]  cand_dist;
  logic [tkpd_pkg::KEY_W-1:0]  cand_key;
  logic                        take_best, take_free_p, take_free_a, take_hit;

  always_comb begin
    rd_p_in   = rd_vld_q && (rd_idx_q < SW'(PENDING_DEPTH));
    rd_a_in   = rd_vld_q && (rd_idx_q < SW'(ACTIVE_DEPTH));
    p_vld     = rd_p_in && pend_vld_q[rd_idx_q[PAW-1:0]];
    a_vld     = rd_a_in && act_vld_q[rd_idx_q[AAW-1:0]];
    // older appends have a larger distance, inverted so lower wins
    cand_dist = seq_q - pend_rdata[tkpd_pkg::SEQ_W-1:0];
    cand_key  = {pend_rdata[tkpd_pkg::ENTRY_W-tkpd_pkg::ID_W-1:tkpd_pkg::SEQ_W], ~cand_dist};
    take_best   = p_vld && (!best_found_q || (cand_key < best_key_q));
    take_free_p = rd_p_in && !p_vld && !free_p_found_q;
    take_free_a = rd_a_in && !a_vld && !free_a_found_q;
    take_hit    = a_vld && (act_rdata == id_q) && !hit_found_q;
  end

  // limit checks, now and after one more dispatch
  logic [SUMW-1:0] load_now, load_nx;

  always_comb begin
    load_now = SUMW'(act_cnt_q) + SUMW'(ext_q);
    load_nx  = load_now + SUMW'(1);
    sts_o.scan_done = (idx_q == SW'(SCAN_N)) && !rd_vld_q;
    sts_o.stop      = (load_now >= SUMW'(max_q)) || (act_cnt_q == ACW'(ACTIVE_DEPTH)) ||
                      (pend_cnt_q == '0) || (disp_cnt_q == tkpd_pkg::MAX_RESULTS);
    sts_o.last_next = (load_nx >= SUMW'(max_q)) ||
                      (act_cnt_q + ACW'(1) == ACW'(ACTIVE_DEPTH)) ||
                      (pend_cnt_q == PCW'(1)) ||
                      (disp_cnt_q + DCW'(1) == tkpd_pkg::MAX_RESULTS);
    sts_o.out_free  = !out_vld_q || rsp_ready_i;
  end

  // counters after the commit of this cycle
  always_comb begin
    pend_cnt_nx = pend_cnt_q;
    act_cnt_nx  = act_cnt_q;
    case (cmd_i.op)
      tkpd_pkg::OP_APPEND:   if (free_p_found_q) pend_cnt_nx = pend_cnt_q + PCW'(1);
      tkpd_pkg::OP_DISPATCH: begin
        pend_cnt_nx = pend_cnt_q - PCW'(1);
        act_cnt_nx  = act_cnt_q + ACW'(1);
      end
      tkpd_pkg::OP_SETTLE:   if (hit_found_q) act_cnt_nx = act_cnt_q - ACW'(1);
      tkpd_pkg::OP_CLEAR: begin
        pend_cnt_nx = '0;
        act_cnt_nx  = '0;
      end
      default: ;
    endcase
  end

  // control state: config, stores, counters, scan, result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q          <= tkpd_pkg::CNT_W'(4);
      seq_q          <= '0;
      pend_vld_q     <= '0;
      act_vld_q      <= '0;
      pend_cnt_q     <= '0;
      act_cnt_q      <= '0;
      disp_cnt_q     <= '0;
      idx_q          <= '0;
      rd_idx_q       <= '0;
      rd_vld_q       <= 1'b0;
      best_found_q   <= 1'b0;
      free_p_found_q <= 1'b0;
      free_a_found_q <= 1'b0;
      hit_found_q    <= 1'b0;
      out_vld_q      <= 1'b0;
    end else begin
      if (cfg_we_i) max_q <= cfg_wdata_i;
      pend_cnt_q <= pend_cnt_nx;
      act_cnt_q  <= act_cnt_nx;
      if (cmd_i.load) disp_cnt_q <= '0;

      // scan stepping
      if (cmd_i.scan_start) begin
        idx_q          <= '0;
        rd_vld_q       <= 1'b0;
        best_found_q   <= 1'b0;
        free_p_found_q <= 1'b0;
        free_a_found_q <= 1'b0;
        hit_found_q    <= 1'b0;
      end else begin
        rd_vld_q <= cmd_i.scan_run && (idx_q != SW'(SCAN_N));
        rd_idx_q <= idx_q;
        if (cmd_i.scan_run && (idx_q != SW'(SCAN_N))) idx_q <= idx_q + SW'(1);
        if (take_best)   best_found_q   <= 1'b1;
        if (take_free_p) free_p_found_q <= 1'b1;
        if (take_free_a) free_a_found_q <= 1'b1;
        if (take_hit)    hit_found_q    <= 1'b1;
      end

      // commits
      case (cmd_i.op)
        tkpd_pkg::OP_APPEND: if (free_p_found_q) begin
          pend_vld_q[free_p_idx_q] <= 1'b1;
          seq_q                    <= seq_q + tkpd_pkg::SEQ_W'(1);
        end
        tkpd_pkg::OP_DISPATCH: begin
          pend_vld_q[best_idx_q]  <= 1'b0;
          act_vld_q[free_a_idx_q] <= 1'b1;
          disp_cnt_q              <= disp_cnt_q + DCW'(1);
        end
        tkpd_pkg::OP_SETTLE: if (hit_found_q) act_vld_q[hit_idx_q] <= 1'b0;
        tkpd_pkg::OP_CLEAR: begin
          pend_vld_q <= '0;
          act_vld_q  <= '0;
        end
        default: ;
      endcase

      // result handshake
      if (cmd_i.op != tkpd_pkg::OP_NONE) out_vld_q <= 1'b1;
      else if (rsp_ready_i) out_vld_q <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      id_q   <= req_id_i;
      tree_q <= req_tree_i;
      prio_q <= req_prio_i;
      ext_q  <= req_ext_i;
    end
    if (take_best) begin
      best_idx_q <= rd_idx_q[PAW-1:0];
      best_key_q <= cand_key;
      best_id_q  <= pend_rdata[tkpd_pkg::ENTRY_W-1 -: tkpd_pkg::ID_W];
    end
    if (take_free_p) free_p_idx_q <= rd_idx_q[PAW-1:0];
    if (take_free_a) free_a_idx_q <= rd_idx_q[AAW-1:0];
    if (take_hit)    hit_idx_q    <= rd_idx_q[AAW-1:0];

    // result fields
    if (cmd_i.op != tkpd_pkg::OP_NONE) begin
      out_id_q   <= '0;
      out_last_q <= 1'b1;
      out_act_q  <= tkpd_pkg::CNT_W'(act_cnt_nx);
      out_pend_q <= tkpd_pkg::CNT_W'(pend_cnt_nx);
      case (cmd_i.op)
        tkpd_pkg::OP_APPEND:
          out_stat_q <= free_p_found_q ? tkpd_pkg::ST_APPENDED : tkpd_pkg::ST_FULL;
        tkpd_pkg::OP_NO_DISPATCH: out_stat_q <= tkpd_pkg::ST_NONE;
        tkpd_pkg::OP_DISPATCH: begin
          out_stat_q <= tkpd_pkg::ST_DISPATCHED;
          out_id_q   <= best_id_q;
          out_last_q <= sts_o.last_next;
        end
        tkpd_pkg::OP_SETTLE:
          out_stat_q <= hit_found_q ? tkpd_pkg::ST_SETTLED : tkpd_pkg::ST_NOT_ACTIVE;
        default: out_stat_q <= tkpd_pkg::ST_CLEARED;
      endcase
    end
  end

  assign rsp_valid_o   = out_vld_q;
  assign rsp_status_o  = out_stat_q;
  assign rsp_id_o      = out_id_q;
  assign rsp_last_o    = out_last_q;
  assign rsp_active_o  = out_act_q;
  assign rsp_pending_o = out_pend_q;

  // counters track the valid bits
  a_pend_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_cnt_q == PCW'($countones(pend_vld_q)))
    else $error("pending count out of step with valid bits");

  a_act_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    act_cnt_q == ACW'($countones(act_vld_q)))
    else $error("active count out of step with valid bits");

  // a dispatch always has a candidate and a free active slot
  a_disp_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == tkpd_pkg::OP_DISPATCH) |-> (best_found_q && free_a_found_q))
    else $error("dispatch without candidate or free slot");

  // no result is overwritten while it waits
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !rsp_ready_i) |-> (cmd_i.op == tkpd_pkg::OP_NONE))
    else $error("result overwritten while stalled");

endmodule

/* hw/rtl/two_key_priority_dispatcher.sv */
// top level of the two-key priority dispatcher
// depends on tkpd_pkg, tkpd_req_if, tkpd_rsp_if, tkpd_ctrl, tkpd_dpath
//
// Takes one request at a time. Append, settle and process each scan the stores
// one entry a cycle over N = max(PENDING_DEPTH, ACTIVE_DEPTH) entries through the
// registered memory read port; clear does not scan, and process runs a new scan
// for each dispatch and none when nothing is dispatched.
// Results leave through an output register, so the next request is taken while
// the last result still waits. The limit register resets to 4.
module two_key_priority_dispatcher #(
  parameter int unsigned PENDING_DEPTH = 64,
  parameter int unsigned ACTIVE_DEPTH  = 64
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [tkpd_pkg::CNT_W-1:0] cfg_wdata_i,
  tkpd_req_if.sink                   req_i,
  tkpd_rsp_if.source                 rsp_o
);

  tkpd_pkg::cmd_t cmd;
  tkpd_pkg::sts_t sts;

  // controller
  tkpd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_func_i  (req_i.func),
    .req_ready_o (req_i.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // datapath
  tkpd_dpath #(
    .PENDING_DEPTH (PENDING_DEPTH),
    .ACTIVE_DEPTH  (ACTIVE_DEPTH)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .req_id_i      (req_i.request_id),
    .req_tree_i    (req_i.tree_priority),
    .req_prio_i    (req_i.request_priority),
    .req_ext_i     (req_i.external_in_flight),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .rsp_valid_o   (rsp_o.valid),
    .rsp_ready_i   (rsp_o.ready),
    .rsp_status_o  (rsp_o.status),
    .rsp_id_o      (rsp_o.dispatched_id),
    .rsp_last_o    (rsp_o.last),
    .rsp_active_o  (rsp_o.active_count),
    .rsp_pending_o (rsp_o.pending_count)
  );

endmodule

/* dv/tkpd_tb_if.sv */
`timescale 1ns / 100ps
// testbench-side copy of nothing: the block's interfaces are reused directly
// this file holds the request and result record types used by the testbench
// depends on tkpd_pkg
package tkpd_tb_pkg;

  typedef struct packed {
    logic [tkpd_pkg::FUNC_W-1:0] func;
    logic [tkpd_pkg::ID_W-1:0]   id;
    logic [tkpd_pkg::PRIO_W-1:0] tree;
    logic [tkpd_pkg::PRIO_W-1:0] prio;
    logic [tkpd_pkg::EXT_W-1:0]  ext;
  } req_t;

  typedef struct packed {
    logic [tkpd_pkg::STAT_W-1:0] status;
    logic [tkpd_pkg::ID_W-1:0]   id;
    logic                        last;
    logic [tkpd_pkg::CNT_W-1:0]  active;
    logic [tkpd_pkg::CNT_W-1:0]  pending;
  } rsp_t;
endpackage

/* dv/two_key_priority_dispatcher_test.sv */
`timescale 1ns / 100ps
// testbench of the two-key priority dispatcher: random and directed requests,
// a behavioural scheduler model predicts every result, a monitor compares them
// depends on tkpd_pkg, tkpd_tb_pkg, tkpd_req_if, tkpd_rsp_if, the dispatcher
module two_key_priority_dispatcher_test;

  localparam int DEPTH = 64;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [tkpd_pkg::CNT_W-1:0] cfg_wdata_i = '0;

  tkpd_req_if req_if ();
  tkpd_rsp_if rsp_if ();

  two_key_priority_dispatcher DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .req_i(req_if.sink), .rsp_o(rsp_if.source)
  );

  always #4 clk_i = ~clk_i;

  // scheduler state kept by the testbench
  logic [tkpd_pkg::ID_W-1:0]   pend_id [DEPTH];
  logic [tkpd_pkg::PRIO_W-1:0] pend_tree [DEPTH];
  logic [tkpd_pkg::PRIO_W-1:0] pend_prio [DEPTH];
  logic [tkpd_pkg::SEQ_W-1:0]  pend_seq [DEPTH];
  logic                        pend_ok [DEPTH];
  logic [tkpd_pkg::ID_W-1:0]   act_id [DEPTH];
  logic                        act_ok [DEPTH];
  logic [tkpd_pkg::SEQ_W-1:0]  seq_ctr;
  int                          limit;

  tkpd_tb_pkg::req_t todo_q[$];
  tkpd_tb_pkg::rsp_t outcome_q[$];
  int   errors = 0;
  bit   hold_go = 1'b0;
  bit   hold_sink = 1'b0;
  bit   pause_src = 1'b0;

  function automatic logic [tkpd_pkg::CNT_W-1:0] n_pend();
    int n = 0;
    for (int i = 0; i < DEPTH; i++) if (pend_ok[i]) n++;
    return n[tkpd_pkg::CNT_W-1:0];
  endfunction

  function automatic logic [tkpd_pkg::CNT_W-1:0] n_act();
    int n = 0;
    for (int i = 0; i < DEPTH; i++) if (act_ok[i]) n++;
    return n[tkpd_pkg::CNT_W-1:0];
  endfunction

  function automatic void add_req(tkpd_tb_pkg::req_t r);
    todo_q.insert(todo_q.size(), r);
  endfunction

  function automatic void push_outcome(logic [tkpd_pkg::STAT_W-1:0] st,
                                       logic [tkpd_pkg::ID_W-1:0] id, logic last);
    tkpd_tb_pkg::rsp_t r;
    r.status = st; r.id = id; r.last = last; r.active = n_act(); r.pending = n_pend();
    outcome_q.insert(outcome_q.size(), r);
  endfunction

  // true when pending slot a is dispatched ahead of slot b
  function automatic bit ahead(int a, int b);
    logic [tkpd_pkg::SEQ_W-1:0] da, db;
    if (pend_tree[a] != pend_tree[b]) return pend_tree[a] < pend_tree[b];
    if (pend_prio[a] != pend_prio[b]) return pend_prio[a] < pend_prio[b];
    da = seq_ctr - pend_seq[a];
    db = seq_ctr - pend_seq[b];
    return da > db;
  endfunction

  function automatic void schedule(tkpd_tb_pkg::req_t r);
    int slot, best, k;
    bit hit;
    case (r.func)
      tkpd_pkg::FUNC_APPEND: begin
        slot = DEPTH;
        for (int i = DEPTH - 1; i >= 0; i--) if (!pend_ok[i]) slot = i;
        if (slot == DEPTH) push_outcome(tkpd_pkg::ST_FULL, '0, 1'b1);
        else begin
          pend_id[slot] = r.id; pend_tree[slot] = r.tree; pend_prio[slot] = r.prio;
          pend_seq[slot] = seq_ctr; pend_ok[slot] = 1'b1;
          seq_ctr++;
          push_outcome(tkpd_pkg::ST_APPENDED, '0, 1'b1);
        end
      end
      tkpd_pkg::FUNC_PROCESS: begin
        k = 0;
        while (k < 64) begin
          if (int'(n_act()) + int'(r.ext) >= limit) break;
          slot = DEPTH;
          for (int i = DEPTH - 1; i >= 0; i--) if (!act_ok[i]) slot = i;
          if (slot == DEPTH) break;
          best = DEPTH;
          for (int i = 0; i < DEPTH; i++)
            if (pend_ok[i] && (best == DEPTH || ahead(i, best))) best = i;
          if (best == DEPTH) break;
          pend_ok[best] = 1'b0;
          act_id[slot] = pend_id[best]; act_ok[slot] = 1'b1;
          push_outcome(tkpd_pkg::ST_DISPATCHED, pend_id[best], 1'b0);
          k++;
        end
        if (k == 0) push_outcome(tkpd_pkg::ST_NONE, '0, 1'b1);
        else outcome_q[$].last = 1'b1;
      end
      tkpd_pkg::FUNC_SETTLE: begin
        hit = 1'b0;
        for (int i = 0; i < DEPTH && !hit; i++)
          if (act_ok[i] && act_id[i] == r.id) begin
            act_ok[i] = 1'b0; hit = 1'b1;
          end
        push_outcome(hit ? tkpd_pkg::ST_SETTLED : tkpd_pkg::ST_NOT_ACTIVE, '0, 1'b1);
      end
      default: begin
        for (int i = 0; i < DEPTH; i++) begin
          pend_ok[i] = 1'b0; act_ok[i] = 1'b0;
        end
        push_outcome(tkpd_pkg::ST_CLEARED, '0, 1'b1);
      end
    endcase
  endfunction

  // request driver: random gaps, fed from todo_q
  int gap = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
      req_if.func <= '0; req_if.request_id <= '0; req_if.tree_priority <= '0;
      req_if.request_priority <= '0; req_if.external_in_flight <= '0;
      gap <= 0;
    end else begin
      if (req_if.valid && req_if.ready) schedule({req_if.func, req_if.request_id,
        req_if.tree_priority, req_if.request_priority, req_if.external_in_flight});
      if (!req_if.valid || req_if.ready) begin
        if (gap > 0 || pause_src || todo_q.size() == 0) begin
          req_if.valid <= 1'b0;
          if (gap > 0) gap <= gap - 1;
        end else begin
          tkpd_tb_pkg::req_t r;
          r = todo_q.pop_front();
          req_if.valid <= 1'b1;
          req_if.func <= r.func; req_if.request_id <= r.id;
          req_if.tree_priority <= r.tree; req_if.request_priority <= r.prio;
          req_if.external_in_flight <= r.ext;
          gap <= ($urandom_range(0, 9) < 6) ? 0 :
                 ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(4, 40);
        end
      end
    end
  end

  // result monitor with random back-pressure
  int stall = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
      stall <= 0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        tkpd_tb_pkg::rsp_t got, want;
        got = {rsp_if.status, rsp_if.dispatched_id, rsp_if.last,
               rsp_if.active_count, rsp_if.pending_count};
        if (outcome_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result %h", got);
        end else begin
          want = outcome_q.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= 10)
              $display({"result mismatch: expected st=%0d id=%0d last=%0d act=%0d pend=%0d,",
                        " got st=%0d id=%0d last=%0d act=%0d pend=%0d"},
                       want.status, want.id, want.last, want.active, want.pending,
                       got.status, got.id, got.last, got.active, got.pending);
          end
        end
      end
      if (hold_sink) rsp_if.ready <= 1'b0;
      else if (stall > 0) begin
        rsp_if.ready <= 1'b0;
        stall <= stall - 1;
      end else begin
        rsp_if.ready <= 1'b1;
        if ($urandom_range(0, 9) < 3)
          stall <= ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(4, 30);
      end
    end
  end

  // long receiver hold-off, counted here
  initial begin
    wait (hold_go);
    hold_sink = 1'b1;
    repeat (400) @(posedge clk_i);
    hold_sink = 1'b0;
  end

  function automatic tkpd_tb_pkg::req_t mk(logic [1:0] f, int id, int tr, int pr, int ex);
    tkpd_tb_pkg::req_t r;
    r.func = f;
    r.id   = id[tkpd_pkg::ID_W-1:0];
    r.tree = tr[tkpd_pkg::PRIO_W-1:0];
    r.prio = pr[tkpd_pkg::PRIO_W-1:0];
    r.ext  = ex[tkpd_pkg::EXT_W-1:0];
    return r;
  endfunction

  function automatic tkpd_tb_pkg::req_t rnd_req(int id_span);
    int sel;
    int unsigned w;
    tkpd_tb_pkg::req_t r;
    sel = $urandom_range(0, 99);
    r = mk(tkpd_pkg::FUNC_APPEND, $urandom_range(0, id_span), $urandom_range(0, 3),
           $urandom_range(0, 3), 0);
    if ($urandom_range(0, 3) == 0) begin
      w = $urandom;
      r.tree = w[15:0]; r.prio = w[31:16];
      w = $urandom;
      r.id = w[tkpd_pkg::ID_W-1:0];
    end
    if (sel < 50) r.func = tkpd_pkg::FUNC_APPEND;
    else if (sel < 72) begin
      r.func = tkpd_pkg::FUNC_PROCESS;
      w = ($urandom_range(0, 5) == 0) ? $urandom : $urandom_range(0, 3);
      r.ext = w[tkpd_pkg::EXT_W-1:0];
    end else if (sel < 97) r.func = tkpd_pkg::FUNC_SETTLE;
    else r.func = tkpd_pkg::FUNC_CLEAR;
    return r;
  endfunction

  task automatic drain();
    while (todo_q.size() != 0 || req_if.valid || outcome_q.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic set_limit(int v);
    @(posedge clk_i);
    cfg_we_i <= 1'b1; cfg_wdata_i <= v[tkpd_pkg::CNT_W-1:0];
    limit = v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // stimulus
  initial begin
    int lims[6] = '{0, 1, 64, 127, 7, 20};
    for (int i = 0; i < DEPTH; i++) begin
      pend_ok[i] = 1'b0; act_ok[i] = 1'b0;
    end
    seq_ctr = '0;
    limit = 4;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty process, key order, age ties, duplicates, unknown settle
    add_req(mk(tkpd_pkg::FUNC_PROCESS, 0, 0, 0, 0));
    add_req(mk(tkpd_pkg::FUNC_SETTLE, 255, 0, 0, 0));
    add_req(mk(tkpd_pkg::FUNC_APPEND, 255, 16'hFFFF, 16'hFFFF, 0));
    add_req(mk(tkpd_pkg::FUNC_APPEND, 1, 5, 9, 0));
    add_req(mk(tkpd_pkg::FUNC_APPEND, 2, 5, 3, 0));
    add_req(mk(tkpd_pkg::FUNC_APPEND, 3, 5, 3, 0));
    add_req(mk(tkpd_pkg::FUNC_APPEND, 3, 0, 16'hFFFF, 0));
    add_req(mk(tkpd_pkg::FUNC_APPEND, 170, 16'hAAAA, 16'h5555, 0));
    add_req(mk(tkpd_pkg::FUNC_PROCESS, 0, 0, 0, 255));
    add_req(mk(tkpd_pkg::FUNC_PROCESS, 0, 0, 0, 1));
    add_req(mk(tkpd_pkg::FUNC_PROCESS, 0, 0, 0, 0));
    add_req(mk(tkpd_pkg::FUNC_SETTLE, 3, 0, 0, 0));
    add_req(mk(tkpd_pkg::FUNC_SETTLE, 2, 0, 0, 0));
    add_req(mk(tkpd_pkg::FUNC_PROCESS, 85, 16'h5555, 16'hAAAA, 170));
    add_req(mk(tkpd_pkg::FUNC_PROCESS, 0, 0, 0, 2));
    add_req(mk(tkpd_pkg::FUNC_CLEAR, 0, 0, 0, 0));
    add_req(mk(tkpd_pkg::FUNC_PROCESS, 0, 0, 0, 0));
    drain();

    // fill the store to overflow with the sink held off
    set_limit(64);
    hold_go = 1'b1;
    for (int i = 0; i < 66; i++) add_req(mk(tkpd_pkg::FUNC_APPEND, $urandom_range(0, 255),
      $urandom_range(0, 2), $urandom_range(0, 65535), 0));
    @(posedge clk_i);
    wait (!hold_sink);
    add_req(mk(tkpd_pkg::FUNC_PROCESS, 0, 0, 0, 0));
    add_req(mk(tkpd_pkg::FUNC_APPEND, 9, 0, 0, 0));
    add_req(mk(tkpd_pkg::FUNC_PROCESS, 0, 0, 0, 0));
    add_req(mk(tkpd_pkg::FUNC_CLEAR, 0, 0, 0, 0));
    drain();

    // random phases over several limits
    foreach (lims[p]) begin
      set_limit(lims[p]);
      for (int i = 0; i < 45; i++) add_req(rnd_req(p < 3 ? 15 : 255));
      if (p == 2) begin
        repeat (300) @(posedge clk_i);
        pause_src = 1'b1;
        while (outcome_q.size() != 0 || req_if.valid) @(posedge clk_i);
        pause_src = 1'b0;
      end
      drain();
    end
    set_limit(4);
    for (int i = 0; i < 30; i++) add_req(rnd_req(15));
    drain();

    if (errors == 0) $display("two_key_priority_dispatcher_test: clean");
    else $display("two_key_priority_dispatcher_test: errors");
    $finish;
  end

  initial begin
    #100ms;
    $display("two_key_priority_dispatcher_test: errors");
    $finish;
  end
endmodule
